// ===== rtl/iwg_pkg.sv =====
// Shared types and constants for the IR wave-gesture lamp switch.
`timescale 1ns / 1ps

package iwg_pkg;

    // Default build values
    localparam int MODE_COUNT_DEF  = 9;
    localparam int LEVEL_COUNT_DEF = 4;
    localparam int OFF_MODE_DEF    = 8;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 8;
    localparam int MODE_W   = 4;
    localparam int LEVEL_W  = 2;
    localparam int EVENT_W  = 2;
    localparam int GAP_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Fixed-point reciprocal used for the modulo reduction of set values
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = VALUE_W + RECIP_SHIFT;

    localparam logic [GAP_W-1:0]   GAP_LIMIT       = 9'd511;
    localparam logic [VALUE_W-1:0] MIN_GAP_RST     = 8'd10;
    localparam logic [VALUE_W-1:0] MAX_GAP_RST     = 8'd80;
    localparam logic [MODE_W-1:0]  MODE_RST        = 4'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_RST       = 2'd3;
    localparam logic [MODE_W-1:0]  SAVED_MODE_RST  = 4'd4;
    localparam logic [LEVEL_W-1:0] SAVED_LEVEL_RST = 2'd2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_MODE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET_LEVEL = 2'd2;

    // Gesture event codes
    localparam logic [EVENT_W-1:0] EV_NONE      = 2'd0;
    localparam logic [EVENT_W-1:0] EV_OFF       = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ON        = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TOO_SHORT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 1'd1;

    // Registered request, with the quotient estimates for both reductions
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               one;
        logic               two;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] mode_q;
        logic [VALUE_W-1:0] level_q;
    } stage_item_t;

endpackage

// ===== rtl/iwg_in_stage.sv =====
// Input register stage: captures a request and estimates the set-value quotients.
`timescale 1ns / 1ps

module iwg_in_stage #(
    parameter int MODE_COUNT  = iwg_pkg::MODE_COUNT_DEF,
    parameter int LEVEL_COUNT = iwg_pkg::LEVEL_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [iwg_pkg::REQ_W-1:0]    req_type,
    input  logic                         ir_one,
    input  logic                         ir_two,
    input  logic [iwg_pkg::VALUE_W-1:0]  set_value,
    output logic                         item_valid,
    input  logic                         item_ready,
    output iwg_pkg::stage_item_t         item
);
    import iwg_pkg::*;

    localparam int MODE_RECIP  = (1 << RECIP_SHIFT) / MODE_COUNT;
    localparam int LEVEL_RECIP = (1 << RECIP_SHIFT) / LEVEL_COUNT;

    logic          valid_reg;
    logic          valid_next;
    stage_item_t   item_reg;
    stage_item_t   item_next;
    logic [PROD_W-1:0] mode_prod;
    logic [PROD_W-1:0] level_prod;
    logic          load;

    // Estimate may be one below the true quotient; fixed up downstream
    assign mode_prod  = PROD_W'(set_value) * PROD_W'(MODE_RECIP);
    assign level_prod = PROD_W'(set_value) * PROD_W'(LEVEL_RECIP);

    assign in_ready = !valid_reg || item_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        item_next.req     = req_type;
        item_next.one     = ir_one;
        item_next.two     = ir_two;
        item_next.value   = set_value;
        item_next.mode_q  = mode_prod[PROD_W-1:RECIP_SHIFT];
        item_next.level_q = level_prod[PROD_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/iwg_core.sv =====
// Gesture tracker, lamp state and result register.
`timescale 1ns / 1ps

module iwg_core #(
    parameter int MODE_COUNT  = iwg_pkg::MODE_COUNT_DEF,
    parameter int LEVEL_COUNT = iwg_pkg::LEVEL_COUNT_DEF,
    parameter int OFF_MODE    = iwg_pkg::OFF_MODE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  iwg_pkg::stage_item_t          item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [iwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iwg_pkg::VALUE_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iwg_pkg::MODE_W-1:0]    lamp_mode,
    output logic [iwg_pkg::LEVEL_W-1:0]   lamp_level,
    output logic [iwg_pkg::EVENT_W-1:0]   gesture_event,
    output logic                          waiting
);
    import iwg_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_TWO,
        PH_WAIT_ONE
    } phase_t;

    localparam logic [MODE_W-1:0]  OFF_CODE = MODE_W'(OFF_MODE);
    localparam logic [VALUE_W-1:0] MODE_DIV  = VALUE_W'(MODE_COUNT);
    localparam logic [VALUE_W-1:0] LEVEL_DIV = VALUE_W'(LEVEL_COUNT);

    phase_t              phase_reg, phase_next;
    logic                prev_one_reg, prev_one_next;
    logic                prev_two_reg, prev_two_next;
    logic                have_prev_reg, have_prev_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [MODE_W-1:0]   saved_mode_reg, saved_mode_next;
    logic [LEVEL_W-1:0]  saved_level_reg, saved_level_next;
    logic [EVENT_W-1:0]  event_reg, event_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  min_gap_reg;
    logic [VALUE_W-1:0]  max_gap_reg;

    logic                take;
    logic                e1, e2, other;
    logic [GAP_W-1:0]    gap_inc;
    logic [VALUE_W-1:0]  mode_rem_est, level_rem_est;
    logic [VALUE_W-1:0]  mode_rem, level_rem;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    // Remainder from the registered quotient estimate, one correction step
    assign mode_rem_est  = item.value - VALUE_W'(item.mode_q * MODE_DIV);
    assign level_rem_est = item.value - VALUE_W'(item.level_q * LEVEL_DIV);
    assign mode_rem  = (mode_rem_est >= MODE_DIV) ? mode_rem_est - MODE_DIV : mode_rem_est;
    assign level_rem = (level_rem_est >= LEVEL_DIV) ? level_rem_est - LEVEL_DIV
                                                    : level_rem_est;

    assign e1      = have_prev_reg && (item.one != prev_one_reg);
    assign e2      = have_prev_reg && (item.two != prev_two_reg);
    assign gap_inc = (gap_reg < GAP_LIMIT) ? gap_reg + 1'b1 : gap_reg;
    assign other   = (phase_reg == PH_WAIT_TWO) ? e2 : e1;

    always_comb
    begin
        phase_next       = phase_reg;
        prev_one_next    = prev_one_reg;
        prev_two_next    = prev_two_reg;
        have_prev_next   = have_prev_reg;
        gap_next         = gap_reg;
        mode_next        = mode_reg;
        level_next       = level_reg;
        saved_mode_next  = saved_mode_reg;
        saved_level_next = saved_level_reg;
        event_next       = event_reg;
        out_valid_next   = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next = 1'b1;
            event_next     = EV_NONE;
            case (item.req)
                REQ_TICK:
                begin
                    prev_one_next  = item.one;
                    prev_two_next  = item.two;
                    have_prev_next = 1'b1;
                    case (phase_reg)
                        PH_WAIT_TWO, PH_WAIT_ONE:
                        begin
                            gap_next = gap_inc;
                            if (other)
                            begin
                                if (gap_inc < GAP_W'(min_gap_reg))
                                begin
                                    event_next = EV_TOO_SHORT;
                                end
                                else if (gap_inc <= GAP_W'(max_gap_reg))
                                begin
                                    if (mode_reg == OFF_CODE)
                                    begin
                                        mode_next  = saved_mode_reg;
                                        level_next = saved_level_reg;
                                        event_next = EV_ON;
                                    end
                                    else
                                    begin
                                        saved_mode_next  = mode_reg;
                                        saved_level_next = level_reg;
                                        mode_next        = OFF_CODE;
                                        event_next       = EV_OFF;
                                    end
                                end
                                phase_next = PH_IDLE;
                            end
                            else if (gap_inc > GAP_W'(max_gap_reg))
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            if (e1)
                            begin
                                phase_next = PH_WAIT_TWO;
                                gap_next   = '0;
                            end
                            else if (e2)
                            begin
                                phase_next = PH_WAIT_ONE;
                                gap_next   = '0;
                            end
                        end
                    endcase
                end
                REQ_SET_MODE:
                begin
                    mode_next = mode_rem[MODE_W-1:0];
                end
                REQ_SET_LEVEL:
                begin
                    level_next = level_rem[LEVEL_W-1:0];
                end
                default:
                begin
                    // unused request: state reported unchanged
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            prev_one_reg    <= 1'b0;
            prev_two_reg    <= 1'b0;
            have_prev_reg   <= 1'b0;
            gap_reg         <= '0;
            mode_reg        <= MODE_RST;
            level_reg       <= LEVEL_RST;
            saved_mode_reg  <= SAVED_MODE_RST;
            saved_level_reg <= SAVED_LEVEL_RST;
            event_reg       <= EV_NONE;
            out_valid_reg   <= 1'b0;
            min_gap_reg     <= MIN_GAP_RST;
            max_gap_reg     <= MAX_GAP_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            prev_one_reg    <= prev_one_next;
            prev_two_reg    <= prev_two_next;
            have_prev_reg   <= have_prev_next;
            gap_reg         <= gap_next;
            mode_reg        <= mode_next;
            level_reg       <= level_next;
            saved_mode_reg  <= saved_mode_next;
            saved_level_reg <= saved_level_next;
            event_reg       <= event_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && (cfg_index == CFG_MIN_GAP))
            begin
                min_gap_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_MAX_GAP))
            begin
                max_gap_reg <= cfg_data;
            end
        end
    end

    // Lamp state only moves when a new result is loaded, so it doubles as the result
    assign out_valid     = out_valid_reg;
    assign lamp_mode     = mode_reg;
    assign lamp_level    = level_reg;
    assign gesture_event = event_reg;
    assign waiting       = (phase_reg == PH_WAIT_TWO) || (phase_reg == PH_WAIT_ONE);

endmodule

// ===== rtl/ir_wave_gesture_toggle.sv =====
// Top level of the IR wave-gesture lamp switch.
`timescale 1ns / 1ps

// Takes one request per clock unless stalled and returns one result per request:
// an input register (which also holds the quotient estimate
// from the reciprocal multiply for set-value reduction) feeds a single update
// step whose output is the result register. Throughput is one transaction per
// cycle while out_ready is high; in_ready follows out_ready combinationally
// when both stages are full. cfg_ready is always high; the user must write gap
// limits only while the block is idle; the block itself does not enforce it.
module ir_wave_gesture_toggle #(
    parameter int MODE_COUNT  = iwg_pkg::MODE_COUNT_DEF,
    parameter int LEVEL_COUNT = iwg_pkg::LEVEL_COUNT_DEF,
    parameter int OFF_MODE    = iwg_pkg::OFF_MODE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iwg_pkg::REQ_W-1:0]     req_type,
    input  logic                          ir_one,
    input  logic                          ir_two,
    input  logic [iwg_pkg::VALUE_W-1:0]   set_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iwg_pkg::MODE_W-1:0]    lamp_mode,
    output logic [iwg_pkg::LEVEL_W-1:0]   lamp_level,
    output logic [iwg_pkg::EVENT_W-1:0]   gesture_event,
    output logic                          waiting,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [iwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iwg_pkg::VALUE_W-1:0]   cfg_data
);
    import iwg_pkg::*;

    logic        item_valid;
    logic        item_ready;
    stage_item_t item;

    iwg_in_stage #(
        .MODE_COUNT  (MODE_COUNT),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .ir_one     (ir_one),
        .ir_two     (ir_two),
        .set_value  (set_value),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    iwg_core #(
        .MODE_COUNT  (MODE_COUNT),
        .LEVEL_COUNT (LEVEL_COUNT),
        .OFF_MODE    (OFF_MODE)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lamp_mode     (lamp_mode),
        .lamp_level    (lamp_level),
        .gesture_event (gesture_event),
        .waiting       (waiting)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the IR wave-gesture lamp switch.
`timescale 1ns / 1ps

module tb_top;
    import iwg_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] LAMP_OFF   = MODE_W'(OFF_MODE_DEF);

    typedef enum logic [1:0] {
        NO_WAVE,
        WAIT_SENSOR_TWO,
        WAIT_SENSOR_ONE
    } wave_phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic [EVENT_W-1:0] gesture;
        logic               busy;
    } lamp_status_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type  = REQ_TICK;
    logic                 ir_one    = 1'b0;
    logic                 ir_two    = 1'b0;
    logic [VALUE_W-1:0]   set_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [MODE_W-1:0]    lamp_mode;
    logic [LEVEL_W-1:0]   lamp_level;
    logic [EVENT_W-1:0]   gesture_event;
    logic                 waiting;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_GAP;
    logic [VALUE_W-1:0]   cfg_data  = '0;

    // Lamp state as the block should hold it
    logic               mdl_prev_one    = 1'b0;
    logic               mdl_prev_two    = 1'b0;
    logic               mdl_have_sample = 1'b0;
    wave_phase_t        mdl_phase       = NO_WAVE;
    logic [GAP_W-1:0]   mdl_gap         = '0;
    logic [MODE_W-1:0]  mdl_mode        = MODE_RST;
    logic [LEVEL_W-1:0] mdl_level       = LEVEL_RST;
    logic [MODE_W-1:0]  mdl_saved_mode  = SAVED_MODE_RST;
    logic [LEVEL_W-1:0] mdl_saved_level = SAVED_LEVEL_RST;
    logic [VALUE_W-1:0] min_gap_cfg     = MIN_GAP_RST;
    logic [VALUE_W-1:0] max_gap_cfg     = MAX_GAP_RST;

    lamp_status_t lamp_status_q[$];

    // Sensor levels last driven on a tick
    logic lvl_one = 1'b0;
    logic lvl_two = 1'b0;

    int send_idle_pct = 22;
    int recv_idle_pct = 73;
    int items_sent    = 0;
    int errors        = 0;

    ir_wave_gesture_toggle u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .ir_one        (ir_one),
        .ir_two        (ir_two),
        .set_value     (set_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lamp_mode     (lamp_mode),
        .lamp_level    (lamp_level),
        .gesture_event (gesture_event),
        .waiting       (waiting),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one accepted transaction to the lamp state and queue its status
    task automatic advance_lamp(input logic [REQ_W-1:0] req, input logic one, input logic two,
                                input logic [VALUE_W-1:0] value);
        lamp_status_t res;
        logic         chg_one;
        logic         chg_two;
        logic         other_chg;
        logic [EVENT_W-1:0] gev;
        gev = EV_NONE;
        if (req == REQ_TICK)
        begin
            chg_one = mdl_have_sample && (one != mdl_prev_one);
            chg_two = mdl_have_sample && (two != mdl_prev_two);
            mdl_prev_one    = one;
            mdl_prev_two    = two;
            mdl_have_sample = 1'b1;
            if (mdl_phase == WAIT_SENSOR_TWO || mdl_phase == WAIT_SENSOR_ONE)
            begin
                if (mdl_gap < GAP_LIMIT)
                    mdl_gap = mdl_gap + 1'b1;
                other_chg = (mdl_phase == WAIT_SENSOR_TWO) ? chg_two : chg_one;
                if (other_chg)
                begin
                    if (mdl_gap < {1'b0, min_gap_cfg})
                        gev = EV_TOO_SHORT;
                    else if (mdl_gap <= {1'b0, max_gap_cfg})
                    begin
                        if (mdl_mode == LAMP_OFF)
                        begin
                            mdl_mode  = mdl_saved_mode;
                            mdl_level = mdl_saved_level;
                            gev = EV_ON;
                        end
                        else
                        begin
                            mdl_saved_mode  = mdl_mode;
                            mdl_saved_level = mdl_level;
                            mdl_mode = LAMP_OFF;
                            gev = EV_OFF;
                        end
                    end
                    mdl_phase = NO_WAVE;
                end
                else if (mdl_gap > {1'b0, max_gap_cfg})
                    mdl_phase = NO_WAVE;
            end
            else
            begin
                mdl_phase = NO_WAVE;
                // sensor one wins when both change together
                if (chg_one)
                begin
                    mdl_phase = WAIT_SENSOR_TWO;
                    mdl_gap   = '0;
                end
                else if (chg_two)
                begin
                    mdl_phase = WAIT_SENSOR_ONE;
                    mdl_gap   = '0;
                end
            end
        end
        else if (req == REQ_SET_MODE)
            mdl_mode = MODE_W'(value % MODE_COUNT_DEF);
        else if (req == REQ_SET_LEVEL)
            mdl_level = LEVEL_W'(value % LEVEL_COUNT_DEF);
        res.mode    = mdl_mode;
        res.level   = mdl_level;
        res.gesture = gev;
        res.busy    = (mdl_phase != NO_WAVE);
        lamp_status_q.push_back(res);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Result side: compare each transaction, then pick the next ready level
    always @(posedge clk)
    begin : result_check
        lamp_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lamp_status_q.size() == 0)
            begin
                $error("unexpected result: lamp_mode %0d lamp_level %0d gesture_event %0d",
                       lamp_mode, lamp_level, gesture_event);
                errors++;
            end
            else
            begin
                want = lamp_status_q.pop_front();
                check_field("lamp_mode", 8'(want.mode), 8'(lamp_mode));
                check_field("lamp_level", 8'(want.level), 8'(lamp_level));
                check_field("gesture_event", 8'(want.gesture), 8'(gesture_event));
                check_field("waiting", 8'(want.busy), 8'(waiting));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_req(input logic [REQ_W-1:0] req, input logic one, input logic two,
                            input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        ir_one    <= one;
        ir_two    <= two;
        set_value <= value;
        do @(posedge clk); while (!in_ready);
        advance_lamp(req, one, two, value);
        items_sent++;
    endtask

    task automatic send_tick(input logic one, input logic two);
        lvl_one = one;
        lvl_two = two;
        send_req(REQ_TICK, one, two, VALUE_W'($urandom));
    endtask

    task automatic send_set();
        send_req(($urandom_range(1) != 0) ? REQ_SET_MODE : REQ_SET_LEVEL,
                 1'($urandom), 1'($urandom), VALUE_W'($urandom));
    endtask

    task automatic send_noise();
        logic [REQ_W-1:0] req;
        req = REQ_W'($urandom_range(3));
        if (req == REQ_TICK)
            send_tick(1'($urandom), 1'($urandom));
        else
            send_req(req, 1'($urandom), 1'($urandom), VALUE_W'($urandom));
    endtask

    // Hold the input side off until every status has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (lamp_status_q.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_MIN_GAP)
            min_gap_cfg = data;
        else
            max_gap_cfg = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gap_window(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
        drain_results();
        write_cfg(CFG_MIN_GAP, lo);
        write_cfg(CFG_MAX_GAP, hi);
    endtask

    // One sensor changes, gap ticks later the other one (if complete)
    task automatic run_wave(input bit one_first, input int gap, input bit complete,
                            input bit noisy);
        int k;
        if (noisy)
            repeat ($urandom_range(2)) send_tick(lvl_one, lvl_two);
        if (one_first)
            send_tick(!lvl_one, lvl_two);
        else
            send_tick(lvl_one, !lvl_two);
        for (k = 1; k < gap; k++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_set();
            send_tick(lvl_one, lvl_two);
        end
        if (complete)
        begin
            // now and then the starting sensor flips again on the same tick
            if (one_first)
                send_tick((noisy && $urandom_range(3) == 0) ? !lvl_one : lvl_one, !lvl_two);
            else
                send_tick(!lvl_one, (noisy && $urandom_range(3) == 0) ? !lvl_two : lvl_two);
        end
    endtask

    // Gaps mostly short, with the window edges favoured; long ones are rare
    function automatic int pick_gap();
        int g;
        case ($urandom_range(5))
            0: g = int'(min_gap_cfg) - 1;
            1: g = int'(min_gap_cfg);
            2: g = int'(max_gap_cfg);
            3: g = int'(max_gap_cfg) + 1;
            default: g = int'($urandom_range(24, 1));
        endcase
        if (g < 1)
            g = 1;
        if (g > 24 && $urandom_range(19) != 0)
            g = int'($urandom_range(24, 1));
        return g;
    endfunction

    task automatic test_first_tick();
        send_tick(1'b1, 1'b1);  // only recorded
        send_tick(1'b0, 1'b0);  // both change: sensor one starts the wait
        send_tick(1'b1, 1'b0);  // starting sensor again, ignored
        send_tick(1'b1, 1'b1);  // gap 2, below the default minimum
    endtask

    task automatic test_set_requests();
        send_req(REQ_SET_MODE, 1'b0, 1'b0, 8'd0);
        send_req(REQ_SET_MODE, 1'b1, 1'b1, 8'd255);
        send_req(REQ_SET_LEVEL, 1'b0, 1'b1, 8'd255);
        send_req(REQ_SET_LEVEL, 1'b1, 1'b0, 8'd0);
        send_req(REQ_UNUSED, 1'b1, 1'b1, 8'hAA);
        send_req(REQ_SET_MODE, 1'b0, 1'b0, VALUE_W'(OFF_MODE_DEF));
    endtask

    task automatic test_gap_window();
        set_gap_window(8'd2, 8'd3);
        run_wave(1'b1, 2, 1'b1, 1'b0);  // lamp back on
        run_wave(1'b0, 3, 1'b1, 1'b0);  // lamp off
        run_wave(1'b1, 5, 1'b0, 1'b0);  // wait runs out
        // window shrinks while waiting, so the late change is dropped
        run_wave(1'b0, 2, 1'b0, 1'b0);
        set_gap_window(8'd0, 8'd0);
        send_tick(!lvl_one, lvl_two);
    endtask

    task automatic test_random_waves(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                                     input int snd_pct, input int rcv_pct, input int n_items);
        int stop_at;
        int pick;
        set_gap_window(lo, hi);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = int'($urandom_range(99));
            if (pick < 72)
                run_wave(1'($urandom), pick_gap(), 1'b1, 1'b1);
            else if (pick < 80)
                run_wave(1'($urandom), pick_gap(), 1'b0, 1'b1);
            else if (pick < 97)
                send_noise();
            else
                drain_results();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_tick();
        test_set_requests();
        test_gap_window();
        test_random_waves(8'd3, 8'd12, 22, 73, 320);
        test_random_waves(8'd0, 8'd255, 73, 22, 320);
        test_random_waves(8'd255, 8'd0, 0, 0, 150);
        test_random_waves(8'd5, 8'd5, 0, 0, 160);
        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
